@@ rtl/bsf_pkg.sv @@
// ---------------------------------------------------------------------------
// bsf_pkg: shared types and constants for the fraction bucket sorter
// Sizes, cell and control structs, and the sequencer state type.
// ---------------------------------------------------------------------------
package bsf_pkg;

   // sizing
   localparam int MAX_ITEMS  = 64;
   localparam int VALUE_BITS = 16;
   localparam int CFG_BITS   = 7;
   localparam int CMP_BITS   = 11;
   localparam int IDX_BITS   = $clog2(MAX_ITEMS);
   localparam int CNT_BITS   = $clog2(MAX_ITEMS + 1);
   localparam int PROD_BITS  = CNT_BITS + VALUE_BITS;

   localparam logic [CFG_BITS-1:0] RESET_COUNT = 7'd64;
   localparam logic [CMP_BITS-1:0] CMP_MAX     = '1;

   // one item on its way into the chain
   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic [IDX_BITS-1:0]   bucket;
   } item_type;

   // contents of one chain cell
   typedef struct packed {
      logic                  valid;
      logic [VALUE_BITS-1:0] value;
      logic [IDX_BITS-1:0]   bucket;
   } cell_type;

   // chain control, common to all cells
   typedef struct packed {
      logic clear;
      logic insert;
      logic shift;
   } ctl_type;

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

endpackage

@@ rtl/bsf_req_if.sv @@
// ---------------------------------------------------------------------------
// bsf_req_if: input word channel
// Valid/ready channel carrying one Q0.16 fraction per word.
// ---------------------------------------------------------------------------
interface bsf_req_if;
   import bsf_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);

endinterface

@@ rtl/bsf_rsp_if.sv @@
// ---------------------------------------------------------------------------
// bsf_rsp_if: result word channel
// Valid/ready channel carrying one sorted value, last flag and count.
// ---------------------------------------------------------------------------
interface bsf_rsp_if;
   import bsf_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] sorted_value;
   logic                  last;
   logic [CMP_BITS-1:0]   comparisons;

   modport source (output valid, output sorted_value, output last, output comparisons,
                   input ready);
   modport sink   (input valid, input sorted_value, input last, input comparisons,
                   output ready);

endinterface

@@ rtl/bucket_sort_fraction.sv @@
// ---------------------------------------------------------------------------
// bucket_sort_fraction: stable bucket sort of Q0.16 fractions
// Loads a run of element_count words into a sorted insertion chain, then
// drains them in ascending order with the comparison count on the last word.
// ---------------------------------------------------------------------------
// One input word is taken per cycle while a run loads; each word is
// registered in the bucket stage and is inserted into the 64-cell chain in
// the next cycle. The chain then drains from its head, one result word per
// cycle that the sink takes, as many words as were loaded; the next run
// loads once the last word has gone out. The insertion compare is broadcast
// across the chain and there is a single drain port at the chain head.
// Writing element_count empties the chain and starts a fresh run.
module bucket_sort_fraction (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [bsf_pkg::CFG_BITS-1:0] csr_write_data,
   bsf_req_if.sink                      req_bus,
   bsf_rsp_if.source                    rsp_bus
);
   import bsf_pkg::*;

   state_type             state_ff, state_in;
   logic [CFG_BITS-1:0]   count_ff, count_in;
   logic [CNT_BITS-1:0]   loaded_ff, loaded_in;
   logic [CMP_BITS-1:0]   total_ff, total_in;
   logic                  a_valid_ff, a_valid_in;
   logic                  a_last_ff, a_last_in;
   item_type              a_item_ff, a_item_in;

   logic [CNT_BITS-1:0]   run_len;
   logic [PROD_BITS-1:0]  product;
   logic                  req_take;
   logic                  rsp_take;
   logic                  full;
   ctl_type               ctl;

   cell_type              cells [MAX_ITEMS];
   logic [MAX_ITEMS-1:0]  le;
   logic [MAX_ITEMS-1:0]  bkt_lt;
   logic [MAX_ITEMS-1:0]  first_gt;
   logic [MAX_ITEMS-1:0]  first_ge_bkt;
   logic [IDX_BITS-1:0]   ins_pos;
   logic [IDX_BITS-1:0]   bkt_start;
   logic [IDX_BITS-1:0]   hits;
   logic [CMP_BITS:0]     total_sum;

   // effective run length: zero acts as one, clamp at chain length
   always_comb begin
      priority if (count_ff == '0) begin
         run_len = CNT_BITS'(1);
      end else if (count_ff > CFG_BITS'(MAX_ITEMS)) begin
         run_len = CNT_BITS'(MAX_ITEMS);
      end else begin
         run_len = CNT_BITS'(count_ff);
      end
   end

   assign full     = (loaded_ff == run_len);
   assign req_take = req_bus.valid && req_bus.ready;
   assign rsp_take = rsp_bus.valid && rsp_bus.ready;

   // bucket stage
   assign product = PROD_BITS'(run_len) * PROD_BITS'(req_bus.value);

   always_comb begin
      a_valid_in       = req_take && !csr_write_enable;
      a_last_in        = (loaded_ff + CNT_BITS'(1)) == run_len;
      a_item_in.value  = req_bus.value;
      a_item_in.bucket = product[VALUE_BITS +: IDX_BITS];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      priority if (csr_write_enable) begin
         state_in = ST_LOAD;
      end else begin
         unique case (state_ff)
            ST_LOAD:  if (a_valid_ff && a_last_ff) state_in = ST_DRAIN;
            ST_DRAIN: if (rsp_take && loaded_ff == CNT_BITS'(1)) state_in = ST_LOAD;
            default:  state_in = ST_LOAD;
         endcase
      end
   end

   // sequencer outputs
   always_comb begin
      req_bus.ready = 1'b0;
      rsp_bus.valid = 1'b0;
      ctl.clear     = csr_write_enable;
      ctl.insert    = 1'b0;
      ctl.shift     = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_bus.ready = !full;
            ctl.insert    = a_valid_ff;
         end
         ST_DRAIN: begin
            rsp_bus.valid = 1'b1;
            ctl.shift     = rsp_bus.ready;
         end
         default: begin
            req_bus.ready = 1'b0;
         end
      endcase
   end

   // insertion chain
   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_chain
      cell_type left_c, right_c;
      logic     left_le_c;
      if (i == 0) begin : g_head
         assign left_c    = '0;
         assign left_le_c = 1'b1;
      end else begin : g_body
         assign left_c    = cells[i-1];
         assign left_le_c = le[i-1];
      end
      if (i == MAX_ITEMS - 1) begin : g_tail
         assign right_c = '0;
      end else begin : g_inner
         assign right_c = cells[i+1];
      end

      bsf_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .new_item   (a_item_ff),
         .left_cell  (left_c),
         .left_le    (left_le_c),
         .right_cell (right_c),
         .entry      (cells[i]),
         .le         (le[i]),
         .bkt_lt     (bkt_lt[i])
      );

      // boundaries of the two sorted prefixes
      if (i == 0) begin : g_edge0
         assign first_gt[i]     = !le[i];
         assign first_ge_bkt[i] = !bkt_lt[i];
      end else begin : g_edgen
         assign first_gt[i]     = !le[i] && le[i-1];
         assign first_ge_bkt[i] = !bkt_lt[i] && bkt_lt[i-1];
      end
   end

   // one-hot to index: insert position and start of the item's bucket
   always_comb begin
      ins_pos   = '0;
      bkt_start = '0;
      for (int i = 0; i < MAX_ITEMS; i++) begin
         if (first_gt[i])     ins_pos   = ins_pos   | IDX_BITS'(i);
         if (first_ge_bkt[i]) bkt_start = bkt_start | IDX_BITS'(i);
      end
   end

   // same-bucket entries not larger than the item sit between the two
   assign hits      = ins_pos - bkt_start;
   assign total_sum = {1'b0, total_ff} + (CMP_BITS + 1)'(hits);

   // run counters
   always_comb begin
      count_in  = count_ff;
      loaded_in = loaded_ff;
      total_in  = total_ff;
      priority if (csr_write_enable) begin
         count_in  = csr_write_data;
         loaded_in = '0;
         total_in  = '0;
      end else if (state_ff == ST_DRAIN) begin
         if (rsp_take) loaded_in = loaded_ff - CNT_BITS'(1);
         if (rsp_take && loaded_ff == CNT_BITS'(1)) total_in = '0;
      end else begin
         if (req_take) loaded_in = loaded_ff + CNT_BITS'(1);
         if (a_valid_ff) begin
            total_in = total_sum[CMP_BITS] ? CMP_MAX : total_sum[CMP_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         count_ff   <= RESET_COUNT;
         loaded_ff  <= '0;
         total_ff   <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         loaded_ff  <= loaded_in;
         total_ff   <= total_in;
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_last_ff <= a_last_in;
      a_item_ff <= a_item_in;
   end

   // result word comes straight from the chain head
   assign rsp_bus.sorted_value = cells[0].value;
   assign rsp_bus.last         = (loaded_ff == CNT_BITS'(1));
   assign rsp_bus.comparisons  = rsp_bus.last ? total_ff : '0;

   // checks
   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> cells[0].valid)
      else $error("result offered from an empty chain head");

   a_no_load_in_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (!req_bus.ready && !a_valid_ff))
      else $error("input activity while draining");

   a_run_closed: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_bus.last) |=> (loaded_ff == '0 && total_ff == '0))
      else $error("run counters not cleared after last word");

   a_ins_order: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff |-> (bkt_start <= ins_pos))
      else $error("bucket start beyond insert position");

endmodule

@@ rtl/bsf_cell.sv @@
// ---------------------------------------------------------------------------
// bsf_cell: one cell of the insertion chain
// Holds one value and its bucket. On insert it keeps its entry, takes the
// new item or takes its left neighbor; on shift it takes its right neighbor; clear empties it.
// ---------------------------------------------------------------------------
module bsf_cell (
   input  logic              clock,
   input  logic              reset,
   input  bsf_pkg::ctl_type  ctl,
   input  bsf_pkg::item_type new_item,
   input  bsf_pkg::cell_type left_cell,
   input  logic              left_le,
   input  bsf_pkg::cell_type right_cell,
   output bsf_pkg::cell_type entry,
   output logic              le,
   output logic              bkt_lt
);
   import bsf_pkg::*;

   logic                  valid_ff, valid_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [IDX_BITS-1:0]   bucket_ff, bucket_in;

   // entry stays ahead of the new item when it is not larger (stable)
   assign le     = valid_ff && (value_ff <= new_item.value);
   assign bkt_lt = valid_ff && (bucket_ff < new_item.bucket);

   assign entry.valid  = valid_ff;
   assign entry.value  = value_ff;
   assign entry.bucket = bucket_ff;

   // next entry
   always_comb begin
      valid_in  = valid_ff;
      value_in  = value_ff;
      bucket_in = bucket_ff;
      priority if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.insert) begin
         if (!le) begin
            if (left_le) begin
               valid_in  = 1'b1;
               value_in  = new_item.value;
               bucket_in = new_item.bucket;
            end else begin
               valid_in  = left_cell.valid;
               value_in  = left_cell.value;
               bucket_in = left_cell.bucket;
            end
         end
      end else if (ctl.shift) begin
         valid_in  = right_cell.valid;
         value_in  = right_cell.value;
         bucket_in = right_cell.bucket;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      bucket_ff <= bucket_in;
   end

endmodule
